### rtl/rems_pkg.sv
// ----------------------------------------------------------------------------
// rems_pkg
// Types and constants shared by the rotary encoder menu setter.
// ----------------------------------------------------------------------------
package rems_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_MENU_SIZE    = 2'd0;
	localparam logic [1:0] CFG_SET_MODE     = 2'd1;
	localparam logic [1:0] CFG_FIELD_SELECT = 2'd2;

	// Calendar field codes
	localparam logic [2:0] FLD_YEAR   = 3'd0;
	localparam logic [2:0] FLD_MONTH  = 3'd1;
	localparam logic [2:0] FLD_DAY    = 3'd2;
	localparam logic [2:0] FLD_HOUR   = 3'd3;
	localparam logic [2:0] FLD_MINUTE = 3'd4;

	// Field ranges
	localparam logic [14:0] YEAR_WRAP  = 15'd10000;
	localparam logic [14:0] YEAR_MAX   = 15'd9999;
	localparam logic [14:0] MONTH_MAX  = 15'd12;
	localparam logic [14:0] DAY_MAX    = 15'd31;
	localparam logic [14:0] HOUR_MAX   = 15'd24;
	localparam logic [14:0] MINUTE_MAX = 15'd59;

	// Steps per detent
	localparam logic [2:0] STEPS_PER_DETENT = 3'd4;

	// Display cursor addresses
	localparam logic [7:0] ADDR_YEAR   = 8'h80;
	localparam logic [7:0] ADDR_MONTH  = 8'h85;
	localparam logic [7:0] ADDR_DAY    = 8'h88;
	localparam logic [7:0] ADDR_HOUR   = 8'hC3;
	localparam logic [7:0] ADDR_MINUTE = 8'hC6;

	// Reciprocals for division by 1000, 100 and 10 of values below 2**14
	localparam logic [28:0] RECIP_1000 = 29'd8389;
	localparam logic [28:0] RECIP_100  = 29'd10486;
	localparam logic [28:0] RECIP_10   = 29'd26215;

	localparam logic [7:0] MENU_SIZE_RESET = 8'd8;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_MENU  = 2'd1,
		EV_VALUE = 2'd2
	} event_t;

	typedef struct packed {
		logic        kind;
		logic        pin_a;
		logic        pin_b;
		logic [13:0] load_value;
	} in_item_t;

	typedef struct packed {
		event_t      event_res;
		logic        turned;
		logic [7:0]  menu_index;
		logic [13:0] set_value;
		logic [3:0]  digit_thousands;
		logic [3:0]  digit_hundreds;
		logic [3:0]  digit_tens;
		logic [3:0]  digit_ones;
		logic [7:0]  display_address;
	} out_item_t;

	typedef struct packed {
		logic [7:0] menu_size;
		logic       set_mode;
		logic [2:0] field_select;
	} cfg_t;

	// Outcome of the state update for one item
	typedef struct packed {
		event_t      event_res;
		logic        turned;
		logic [7:0]  menu_index;
		logic [13:0] set_value;
	} step_res_t;

	function automatic logic [7:0] field_address(input logic [2:0] fld);
		logic [7:0] addr;
		case (fld)
			FLD_YEAR:   addr = ADDR_YEAR;
			FLD_MONTH:  addr = ADDR_MONTH;
			FLD_DAY:    addr = ADDR_DAY;
			FLD_HOUR:   addr = ADDR_HOUR;
			FLD_MINUTE: addr = ADDR_MINUTE;
			default:    addr = 8'h00;
		endcase
		return addr;
	endfunction

endpackage

### rtl/rems_decode.sv
// ----------------------------------------------------------------------------
// rems_decode
// Quadrature step decoding, detent counting and menu/value update.
// ----------------------------------------------------------------------------
module rems_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  rems_pkg::in_item_t    item,
	input  rems_pkg::cfg_t        cfg,
	output rems_pkg::step_res_t   res
);

	logic [1:0]  prev_pins_q;
	logic [2:0]  cw_steps_q;
	logic [2:0]  ccw_steps_q;
	logic [7:0]  menu_pos_q;
	logic [13:0] field_val_q;

	logic [1:0]  prev_pins_d;
	logic [2:0]  cw_steps_d;
	logic [2:0]  ccw_steps_d;
	logic [7:0]  menu_pos_d;
	logic [13:0] field_val_d;
	rems_pkg::event_t ev;
	logic        turned;

	always_comb begin
		logic [1:0]  now_pins;
		logic [1:0]  diff;
		logic        mixed;
		logic        cw;
		logic        detent;
		logic [2:0]  cnt;
		logic [7:0]  last;
		logic [14:0] t;
		logic [14:0] v;

		prev_pins_d = prev_pins_q;
		cw_steps_d  = cw_steps_q;
		ccw_steps_d = ccw_steps_q;
		menu_pos_d  = menu_pos_q;
		field_val_d = field_val_q;
		ev          = rems_pkg::EV_NONE;
		turned      = 1'b0;

		now_pins = {item.pin_b, item.pin_a};
		diff     = now_pins ^ prev_pins_q;
		mixed    = (now_pins == 2'd1) || (now_pins == 2'd2);
		cw       = (diff == 2'd2) ? mixed : !mixed;
		detent   = 1'b0;
		cnt      = 3'd0;
		last     = cfg.menu_size - 8'd1;
		t        = cw ? ({1'b0, field_val_q} + 15'd1) : ({1'b0, field_val_q} - 15'd1);
		v        = t;

		if (item.kind) begin
			field_val_d = item.load_value;
		end else if (diff != 2'd0) begin
			prev_pins_d = now_pins;
			turned      = 1'b1;
			if (cw) begin
				ccw_steps_d = 3'd0;
				cnt         = cw_steps_q + 3'd1;
				detent      = (cnt == rems_pkg::STEPS_PER_DETENT);
				cw_steps_d  = detent ? 3'd0 : cnt;
			end else begin
				cw_steps_d  = 3'd0;
				cnt         = ccw_steps_q + 3'd1;
				detent      = (cnt == rems_pkg::STEPS_PER_DETENT);
				ccw_steps_d = detent ? 3'd0 : cnt;
			end
		end

		// A decrement from zero shows as t wrapping to all ones; the calendar field
		// rules below catch it before t is used, other field codes keep the wrap.
		case (cfg.field_select)
			rems_pkg::FLD_YEAR: begin
				if (!cw && field_val_q == 14'd0)
					v = rems_pkg::YEAR_MAX;
				else if (t >= rems_pkg::YEAR_WRAP)
					v = t - rems_pkg::YEAR_WRAP;
			end
			rems_pkg::FLD_MONTH: begin
				if (!cw && field_val_q <= 14'd1)
					v = rems_pkg::MONTH_MAX;
				else if (t > rems_pkg::MONTH_MAX)
					v = 15'd1;
			end
			rems_pkg::FLD_DAY: begin
				if (!cw && field_val_q <= 14'd1)
					v = rems_pkg::DAY_MAX;
				else if (t > rems_pkg::DAY_MAX)
					v = 15'd1;
			end
			rems_pkg::FLD_HOUR: begin
				if (!cw && field_val_q <= 14'd1)
					v = rems_pkg::HOUR_MAX;
				else if (t > rems_pkg::HOUR_MAX)
					v = 15'd1;
			end
			rems_pkg::FLD_MINUTE: begin
				if (!cw && field_val_q == 14'd0)
					v = rems_pkg::MINUTE_MAX;
				else if (t > rems_pkg::MINUTE_MAX)
					v = 15'd0;
			end
			default: v = t;
		endcase

		if (detent) begin
			if (cfg.set_mode) begin
				field_val_d = v[13:0];
				ev          = rems_pkg::EV_VALUE;
			end else begin
				if (cw)
					menu_pos_d = (menu_pos_q == last) ? 8'd0 : menu_pos_q + 8'd1;
				else
					menu_pos_d = (menu_pos_q == 8'd0) ? last : menu_pos_q - 8'd1;
				ev = rems_pkg::EV_MENU;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pins_q <= 2'd0;
			cw_steps_q  <= 3'd0;
			ccw_steps_q <= 3'd0;
			menu_pos_q  <= 8'd0;
			field_val_q <= 14'd0;
		end else if (step_en) begin
			prev_pins_q <= prev_pins_d;
			cw_steps_q  <= cw_steps_d;
			ccw_steps_q <= ccw_steps_d;
			menu_pos_q  <= menu_pos_d;
			field_val_q <= field_val_d;
		end
	end

	assign res.event_res  = ev;
	assign res.turned     = turned;
	assign res.menu_index = menu_pos_d;
	assign res.set_value  = field_val_d;

endmodule

### rtl/rems_digits.sv
// ----------------------------------------------------------------------------
// rems_digits
// Splits a set value into decimal digits by reciprocal multiplication.
// ----------------------------------------------------------------------------
module rems_digits (
	input  logic [13:0] value,
	input  logic        show,
	input  logic        year,
	output logic [3:0]  thousands,
	output logic [3:0]  hundreds,
	output logic [3:0]  tens,
	output logic [3:0]  ones
);

	logic [28:0] p1000;
	logic [28:0] p100;
	logic [28:0] p10;
	logic [3:0]  q1000;
	logic [7:0]  q100;
	logic [10:0] q10;
	logic [7:0]  hu_w;
	logic [10:0] te_w;
	logic [13:0] on_w;

	// The three quotients are independent, so the multipliers sit in parallel.
	assign p1000 = 29'(value) * rems_pkg::RECIP_1000;
	assign p100  = 29'(value) * rems_pkg::RECIP_100;
	assign p10   = 29'(value) * rems_pkg::RECIP_10;

	assign q1000 = p1000[26:23];
	assign q100  = p100[27:20];
	assign q10   = p10[28:18];

	assign hu_w = q100 - 8'(q1000) * 8'd10;
	assign te_w = q10 - 11'(q100) * 11'd10;
	assign on_w = value - 14'(q10) * 14'd10;

	assign thousands = (show && year) ? q1000 : 4'd0;
	assign hundreds  = (show && year) ? hu_w[3:0] : 4'd0;
	assign tens      = show ? te_w[3:0] : 4'd0;
	assign ones      = show ? on_w[3:0] : 4'd0;

endmodule

### rtl/rotary_encoder_menu_setter_core.sv
// ----------------------------------------------------------------------------
// rotary_encoder_menu_setter_core
// Rotary encoder decoder driving a menu index or a calendar field value.
// ----------------------------------------------------------------------------
// Each item is one sample of the encoder pins or a preset of the set value,
// and gives exactly one result item. The block takes one item per cycle
// while the output is not stalled. Each item passes an input register, the
// decode stage, whose state update is the loop that bounds the rate and whose
// result is registered, and an output register holding the digits and
// display address. The stages move independently, so up to two further items
// are accepted while a result waits to be taken. Configuration is taken at
// once and should be written only while no item is in flight.
module rotary_encoder_menu_setter_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  rems_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output rems_pkg::out_item_t  out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [13:0]          cfg_data
);

	rems_pkg::cfg_t      cfg_q;
	logic                valid_s1;
	rems_pkg::in_item_t  item_s1;
	logic                valid_s2;
	rems_pkg::step_res_t res_s2;
	rems_pkg::step_res_t res_d;
	logic                out_valid_q;
	rems_pkg::out_item_t out_item_q;

	logic ready_out;
	logic ready_s2;
	logic ready_s1;
	logic adv1;
	logic adv2;
	logic show;
	logic [3:0] th_w, hu_w, te_w, on_w;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.menu_size    <= rems_pkg::MENU_SIZE_RESET;
			cfg_q.set_mode     <= 1'b0;
			cfg_q.field_select <= rems_pkg::FLD_YEAR;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rems_pkg::CFG_MENU_SIZE:    cfg_q.menu_size    <= cfg_data[7:0];
				rems_pkg::CFG_SET_MODE:     cfg_q.set_mode     <= cfg_data[0];
				rems_pkg::CFG_FIELD_SELECT: cfg_q.field_select <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its content moves on in this cycle.
	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign adv1      = valid_s1 && ready_s2;
	assign adv2      = valid_s2 && ready_out;
	assign in_stall  = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1)
				valid_s1 <= in_valid;
			if (ready_s2)
				valid_s2 <= valid_s1;
			if (ready_out)
				out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && ready_s1)
			item_s1 <= in_item;
		if (adv1)
			res_s2 <= res_d;
		if (adv2) begin
			out_item_q.event_res       <= res_s2.event_res;
			out_item_q.turned          <= res_s2.turned;
			out_item_q.menu_index      <= res_s2.menu_index;
			out_item_q.set_value       <= res_s2.set_value;
			out_item_q.digit_thousands <= th_w;
			out_item_q.digit_hundreds  <= hu_w;
			out_item_q.digit_tens      <= te_w;
			out_item_q.digit_ones      <= on_w;
			out_item_q.display_address <=
				show ? rems_pkg::field_address(cfg_q.field_select) : 8'h00;
		end
	end

	rems_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv1),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	assign show = (res_s2.event_res == rems_pkg::EV_VALUE) &&
		(cfg_q.field_select <= rems_pkg::FLD_MINUTE);

	rems_digits u_digits (
		.value     (res_s2.set_value),
		.show      (show),
		.year      (cfg_q.field_select == rems_pkg::FLD_YEAR),
		.thousands (th_w),
		.hundreds  (hu_w),
		.tens      (te_w),
		.ones      (on_w)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

### rtl/rems_checker.sv
// ----------------------------------------------------------------------------
// rems_checker
// Port-level checks on the result channel of the encoder menu setter.
// ----------------------------------------------------------------------------
module rems_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input rems_pkg::out_item_t out_item
);

	// A result held back by the receiver stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// Digits and address are only shown for a value change.
	a_digits_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.event_res != rems_pkg::EV_VALUE |->
		out_item.digit_thousands == 4'd0 && out_item.digit_hundreds == 4'd0 &&
		out_item.digit_tens == 4'd0 && out_item.digit_ones == 4'd0 &&
		out_item.display_address == 8'h00)
		else $error("digits shown without a value change");

	// A detent can only come from a sample in which the pins changed.
	a_event_turn: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.turned |-> out_item.event_res == rems_pkg::EV_NONE)
		else $error("event reported without pin change");

	// Shown digits are decimal.
	a_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.digit_tens <= 4'd9 && out_item.digit_ones <= 4'd9 &&
		out_item.digit_hundreds <= 4'd9 && out_item.digit_thousands <= 4'd9)
		else $error("digit out of decimal range");

endmodule

bind rotary_encoder_menu_setter_core rems_checker u_rems_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

### tb/rotary_encoder_menu_setter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_menu_setter_core_tb
// Self-checking bench for the rotary encoder menu setter core. Encoder pin
// samples and presets are sent in random bursts. Each accepted item is run
// through a behavioural decoder in the bench. The results that it predicts
// are compared field by field with what the core returns, while the output
// side stalls at random. The configuration is changed between phases, once
// the core has gone idle, to cover menu sizes, both modes and every field.
// ----------------------------------------------------------------------------
module rotary_encoder_menu_setter_core_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_CAP   = 200;

	// Field select codes that have no calendar field behind them
	localparam logic [2:0] FLD_UNUSED_LO = 3'd5;
	localparam logic [2:0] FLD_UNUSED_HI = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	rems_pkg::in_item_t  in_item = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	rems_pkg::out_item_t out_item;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = rems_pkg::CFG_MENU_SIZE;
	logic [13:0]         cfg_data = '0;

	rotary_encoder_menu_setter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Decoder state and configuration as the bench believes them to be
	logic [7:0]  menu_size_cfg = rems_pkg::MENU_SIZE_RESET;
	logic        set_mode_cfg = 1'b0;
	logic [2:0]  field_sel_cfg = rems_pkg::FLD_YEAR;
	logic [1:0]  prev_pins = 2'b00;
	logic [2:0]  cw_steps = '0;
	logic [2:0]  ccw_steps = '0;
	logic [7:0]  menu_pos = '0;
	logic [13:0] field_val = '0;

	logic [7:0] field_cursor [5] = '{rems_pkg::ADDR_YEAR, rems_pkg::ADDR_MONTH,
		rems_pkg::ADDR_DAY, rems_pkg::ADDR_HOUR, rems_pkg::ADDR_MINUTE};

	rems_pkg::in_item_t  sample_queue [$];
	rems_pkg::out_item_t awaited_results [$];
	rems_pkg::in_item_t  next_item;

	int   error_count = 0;
	int   cycle_count = 0;
	int   gap_max = 0;
	int   stall_pct = 0;
	bit   hold_off = 1'b0;
	int   burst_left = 0;
	int   gap_left = 0;

	// Pin pair and turning direction of the stimulus generator
	logic [1:0] gen_pins = 2'b00;
	bit         gen_cw = 1'b1;

	// One detent in set mode, wrapped to the range of the selected field
	function automatic logic [13:0] adjusted_field(input int dir);
		int v;
		v = int'(field_val) + dir;
		case (field_sel_cfg)
			rems_pkg::FLD_YEAR: begin
				if (v < 0) v = int'(rems_pkg::YEAR_MAX);
				v = v % int'(rems_pkg::YEAR_WRAP);
			end
			rems_pkg::FLD_MONTH: begin
				if (v < 1) v = int'(rems_pkg::MONTH_MAX);
				if (v > int'(rems_pkg::MONTH_MAX)) v = 1;
			end
			rems_pkg::FLD_DAY: begin
				if (v < 1) v = int'(rems_pkg::DAY_MAX);
				if (v > int'(rems_pkg::DAY_MAX)) v = 1;
			end
			rems_pkg::FLD_HOUR: begin
				if (v < 1) v = int'(rems_pkg::HOUR_MAX);
				if (v > int'(rems_pkg::HOUR_MAX)) v = 1;
			end
			rems_pkg::FLD_MINUTE: begin
				if (v < 0) v = int'(rems_pkg::MINUTE_MAX);
				if (v > int'(rems_pkg::MINUTE_MAX)) v = 0;
			end
			default: ;
		endcase
		return v[13:0];
	endfunction

	// Updates the decoder state for one item and returns the result it gives
	function automatic rems_pkg::out_item_t predict_encoder(input rems_pkg::in_item_t it);
		rems_pkg::out_item_t r;
		logic [1:0] now;
		logic [1:0] diff;
		logic [7:0] last;
		logic       mixed;
		logic       cw;
		logic       detent;
		int         v;
		r = '0;
		r.event_res = rems_pkg::EV_NONE;
		if (it.kind) begin
			field_val = it.load_value;
		end else begin
			now = {it.pin_b, it.pin_a};
			diff = now ^ prev_pins;
			if (diff != 2'b00) begin
				mixed = (now == 2'd1) || (now == 2'd2);
				cw = (diff == 2'd2) ? mixed : !mixed;
				prev_pins = now;
				r.turned = 1'b1;
				if (cw) begin
					ccw_steps = '0;
					cw_steps = cw_steps + 3'd1;
					detent = (cw_steps >= rems_pkg::STEPS_PER_DETENT);
					if (detent) cw_steps = '0;
				end else begin
					cw_steps = '0;
					ccw_steps = ccw_steps + 3'd1;
					detent = (ccw_steps >= rems_pkg::STEPS_PER_DETENT);
					if (detent) ccw_steps = '0;
				end
				if (detent && set_mode_cfg) begin
					field_val = adjusted_field(cw ? 1 : -1);
					r.event_res = rems_pkg::EV_VALUE;
				end else if (detent) begin
					// A menu size of zero means 256 entries
					last = menu_size_cfg - 8'd1;
					if (cw) menu_pos = (menu_pos == last) ? 8'd0 : menu_pos + 8'd1;
					else menu_pos = (menu_pos == 8'd0) ? last : menu_pos - 8'd1;
					r.event_res = rems_pkg::EV_MENU;
				end
			end
		end
		if (r.event_res == rems_pkg::EV_VALUE && field_sel_cfg <= rems_pkg::FLD_MINUTE) begin
			v = int'(field_val);
			r.display_address = field_cursor[field_sel_cfg];
			if (field_sel_cfg == rems_pkg::FLD_YEAR) begin
				r.digit_thousands = 4'(v / 1000);
				r.digit_hundreds = 4'((v % 1000) / 100);
			end
			r.digit_tens = 4'((v % 100) / 10);
			r.digit_ones = 4'(v % 10);
		end
		r.menu_index = menu_pos;
		r.set_value = field_val;
		return r;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			error_count++;
			if (error_count <= REPORT_CAP)
				$display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_result(input rems_pkg::out_item_t got);
		rems_pkg::out_item_t want;
		if (awaited_results.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_CAP)
				$display("%0t ns: result expected none, actual %h", $time, got);
		end else begin
			want = awaited_results.pop_front();
			check_field("event_res", int'(want.event_res), int'(got.event_res));
			check_field("turned", int'(want.turned), int'(got.turned));
			check_field("menu_index", int'(want.menu_index), int'(got.menu_index));
			check_field("set_value", int'(want.set_value), int'(got.set_value));
			check_field("digit_thousands", int'(want.digit_thousands),
				int'(got.digit_thousands));
			check_field("digit_hundreds", int'(want.digit_hundreds),
				int'(got.digit_hundreds));
			check_field("digit_tens", int'(want.digit_tens), int'(got.digit_tens));
			check_field("digit_ones", int'(want.digit_ones), int'(got.digit_ones));
			check_field("display_address", int'(want.display_address),
				int'(got.display_address));
		end
	endtask

	// Sender: bursts of random length with random gaps in between
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				awaited_results.push_back(predict_encoder(in_item));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (hold_off || sample_queue.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					next_item = sample_queue.pop_front();
					in_valid <= 1'b1;
					in_item <= next_item;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(24, 1);
						gap_left <= (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
					end
				end
			end
		end
	end

	// Receiver: checks every result taken and stalls at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_result(out_item);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rotary_encoder_menu_setter_core_tb: FAIL");
			$finish;
		end
	end

	task automatic queue_sample(input logic [1:0] pins);
		rems_pkg::in_item_t it;
		it.kind = 1'b0;
		it.pin_a = pins[0];
		it.pin_b = pins[1];
		it.load_value = 14'($urandom_range(16383));
		gen_pins = pins;
		sample_queue.push_back(it);
	endtask

	task automatic queue_load(input logic [13:0] value);
		rems_pkg::in_item_t it;
		it.kind = 1'b1;
		it.pin_a = 1'($urandom_range(1));
		it.pin_b = 1'($urandom_range(1));
		it.load_value = value;
		sample_queue.push_back(it);
	endtask

	// Gray sequence {b,a}: clockwise 0-2-3-1, counterclockwise 0-1-3-2
	task automatic queue_turns(input bit cw, input int steps);
		logic [1:0] cw_next [4];
		logic [1:0] ccw_next [4];
		cw_next = '{2'd2, 2'd0, 2'd3, 2'd1};
		ccw_next = '{2'd1, 2'd3, 2'd0, 2'd2};
		repeat (steps) queue_sample(cw ? cw_next[gen_pins] : ccw_next[gen_pins]);
	endtask

	// Mostly clean turning with random reversals, plus repeats, jumps and presets
	task automatic queue_random(input int count, input int load_max);
		int pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 8) gen_cw = !gen_cw;
			if (pick < 72) queue_turns(gen_cw, 1);
			else if (pick < 80) queue_sample(gen_pins);
			else if (pick < 87) queue_sample(2'($urandom_range(3)));
			else if (pick < 95) queue_load(14'($urandom_range(load_max)));
			else queue_load(14'($urandom_range(16383)));
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [13:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			rems_pkg::CFG_MENU_SIZE:    menu_size_cfg = value[7:0];
			rems_pkg::CFG_SET_MODE:     set_mode_cfg = value[0];
			rems_pkg::CFG_FIELD_SELECT: field_sel_cfg = value[2:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (sample_queue.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic [7:0] msize, input logic smode,
		input logic [2:0] fsel, input int gmax, input int spct, input int count,
		input int load_max, input bit pause);
		write_reg(rems_pkg::CFG_MENU_SIZE, {6'd0, msize});
		write_reg(rems_pkg::CFG_SET_MODE, {13'd0, smode});
		write_reg(rems_pkg::CFG_FIELD_SELECT, {11'd0, fsel});
		@(negedge clk);
		gap_max = gmax;
		stall_pct = spct;
		if (smode) begin
			// Step over the top of the field range, then below its bottom
			queue_load(14'(load_max));
			queue_turns(1'b1, 4);
			queue_load('0);
			queue_turns(1'b0, 4);
		end
		queue_random(count, load_max);
		if (pause) begin
			while (sample_queue.size() > count / 2) @(negedge clk);
			hold_off = 1'b1;
			while (in_valid || awaited_results.size() != 0) @(negedge clk);
			hold_off = 1'b0;
		end
		wait_drained();
	endtask

	initial begin
		int settle;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items under the reset configuration: detents both ways,
		// menu wrap at both ends, a repeated sample, both pins changing at
		// once, a reversal mid-detent and presets at the extremes.
		gap_max = 3;
		stall_pct = 30;
		queue_turns(1'b1, 4);
		queue_turns(1'b0, 4);
		queue_turns(1'b0, 4);
		queue_turns(1'b1, 4);
		queue_sample(gen_pins);
		queue_sample(~gen_pins);
		queue_sample(~gen_pins);
		queue_turns(1'b1, 2);
		queue_turns(1'b0, 2);
		queue_load(14'h3FFF);
		queue_load('0);
		queue_random(80, 9999);
		wait_drained();

		run_phase(8'd1, 1'b0, rems_pkg::FLD_YEAR, 0, 0, 120, 9999, 1'b0);
		run_phase(8'd255, 1'b0, rems_pkg::FLD_MINUTE, 6, 60, 150, 9999, 1'b0);
		run_phase(8'd0, 1'b0, rems_pkg::FLD_DAY, 2, 20, 100, 9999, 1'b0);
		run_phase(8'd3, 1'b0, rems_pkg::FLD_HOUR, 1, 10, 100, 9999, 1'b0);
		run_phase(8'd255, 1'b1, rems_pkg::FLD_YEAR, 4, 40, 170, 9999, 1'b1);
		run_phase(8'd5, 1'b1, rems_pkg::FLD_MONTH, 0, 0, 180, 12, 1'b0);
		run_phase(8'd5, 1'b1, rems_pkg::FLD_DAY, 5, 75, 180, 31, 1'b0);
		run_phase(8'd1, 1'b1, rems_pkg::FLD_HOUR, 2, 30, 180, 24, 1'b0);
		run_phase(8'd0, 1'b1, rems_pkg::FLD_MINUTE, 3, 50, 180, 59, 1'b0);
		run_phase(8'd8, 1'b1, FLD_UNUSED_HI, 2, 25, 80, 16383, 1'b0);
		run_phase(8'd8, 1'b1, FLD_UNUSED_LO, 0, 10, 60, 16383, 1'b0);
		run_phase(8'd8, 1'b0, rems_pkg::FLD_YEAR, 1, 0, 60, 9999, 1'b0);

		settle = 0;
		while (awaited_results.size() != 0 && settle < 5000) begin
			@(negedge clk);
			settle++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (awaited_results.size() != 0) begin
			error_count++;
			$display("%0t ns: %0d results expected, actual none", $time,
				awaited_results.size());
		end
		if (error_count == 0)
			$display("rotary_encoder_menu_setter_core_tb: PASS");
		else
			$display("rotary_encoder_menu_setter_core_tb: FAIL");
		$finish;
	end

endmodule
